/* hdl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and helpers for the sliding window mean block.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int VALUE_W    = 32;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = VALUE_W + $clog2(MAX_WINDOW);
	localparam int BITS_W     = $clog2(SUM_W + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int LEN_RESET  = 64;

	// register index, taken from paddr[ADDR_W-1:2]
	localparam logic [ADDR_W-3:0] REG_WINDOW_LEN = '0;

	typedef struct packed {
		logic signed [SUM_W-1:0] total;
		logic [CNT_W-1:0]        count;
	} entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} back_state_t;

	// clamp the register to 1..MAX_WINDOW
	function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] wl);
		logic [CNT_W-1:0] n;
		n = wl;
		if (n == '0)
			n = CNT_W'(1);
		if (n > CNT_W'(MAX_WINDOW))
			n = CNT_W'(MAX_WINDOW);
		return n;
	endfunction

endpackage

/* hdl/swm_ram.sv */
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/swm_front.sv */
// ----------------------------------------------------------------------------
// swm_front
// Accepts samples, maintains the ring store, pointer, count and running sum.
// ----------------------------------------------------------------------------
module swm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic [swm_pkg::CNT_W-1:0]           len,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [swm_pkg::VALUE_W-1:0]  value,
	input  swm_pkg::q_status_t                  q_status,
	output logic                                push,
	output swm_pkg::entry_t                     entry
);

	swm_pkg::front_state_t state_q, state_d;

	logic [swm_pkg::PTR_W-1:0]         ptr_q;
	logic [swm_pkg::CNT_W-1:0]         cnt_q;
	logic signed [swm_pkg::SUM_W-1:0]  total_q;
	logic signed [swm_pkg::VALUE_W-1:0] sample_q;

	logic [swm_pkg::VALUE_W-1:0] old_word;
	logic                        full;
	logic                        we;
	logic [swm_pkg::PTR_W-1:0]   waddr;
	logic [swm_pkg::CNT_W:0]     slot_sum;
	logic [swm_pkg::CNT_W:0]     slot_wrap;
	logic [swm_pkg::CNT_W-1:0]   ptr_inc;
	logic [swm_pkg::PTR_W-1:0]   ptr_next;
	logic [swm_pkg::CNT_W-1:0]   cnt_next;
	logic signed [swm_pkg::SUM_W-1:0] total_next;

	swm_ram #(
		.WIDTH (swm_pkg::VALUE_W),
		.DEPTH (swm_pkg::MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (sample_q),
		.raddr (ptr_q),
		.rdata (old_word)
	);

	always_comb begin
		full      = (cnt_q == len);
		slot_sum  = (swm_pkg::CNT_W + 1)'(ptr_q) + (swm_pkg::CNT_W + 1)'(cnt_q);
		slot_wrap = (slot_sum >= (swm_pkg::CNT_W + 1)'(len)) ?
			slot_sum - (swm_pkg::CNT_W + 1)'(len) : slot_sum;
		ptr_inc   = swm_pkg::CNT_W'(ptr_q) + swm_pkg::CNT_W'(1);
		if (full) begin
			waddr      = ptr_q;
			ptr_next   = (ptr_inc >= len) ? '0 : ptr_inc[swm_pkg::PTR_W-1:0];
			cnt_next   = cnt_q;
			total_next = total_q + swm_pkg::SUM_W'(sample_q)
				- swm_pkg::SUM_W'($signed(old_word));
		end else begin
			waddr      = slot_wrap[swm_pkg::PTR_W-1:0];
			ptr_next   = ptr_q;
			cnt_next   = cnt_q + swm_pkg::CNT_W'(1);
			total_next = total_q + swm_pkg::SUM_W'(sample_q);
		end
	end

	// state machine
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		push         = 1'b0;
		we           = 1'b0;
		unique case (state_q)
			swm_pkg::F_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid)
					state_d = swm_pkg::F_UPDATE;
			end
			swm_pkg::F_UPDATE: begin
				if (!q_status.full) begin
					push    = 1'b1;
					we      = 1'b1;
					state_d = swm_pkg::F_IDLE;
				end
			end
			default: state_d = swm_pkg::F_IDLE;
		endcase
	end

	assign entry.total = total_next;
	assign entry.count = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::F_IDLE;
			ptr_q   <= '0;
			cnt_q   <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				ptr_q   <= '0;
				cnt_q   <= '0;
				total_q <= '0;
			end else if (push) begin
				ptr_q   <= ptr_next;
				cnt_q   <= cnt_next;
				total_q <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready)
			sample_q <= value;
	end

endmodule

/* hdl/swm_queue.sv */
// ----------------------------------------------------------------------------
// swm_queue
// Short FIFO of sum/count words between the front and the divider.
// ----------------------------------------------------------------------------
module swm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  swm_pkg::entry_t    push_entry,
	input  logic               pop,
	output swm_pkg::entry_t    pop_entry,
	output swm_pkg::q_status_t status
);

	swm_pkg::entry_t             mem_q [swm_pkg::QDEPTH];
	logic [swm_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
	logic [swm_pkg::QCNT_W-1:0]  cnt_q;

	assign status.full  = (cnt_q == swm_pkg::QCNT_W'(swm_pkg::QDEPTH));
	assign status.valid = (cnt_q != '0);
	assign pop_entry    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == swm_pkg::QPTR_W'(swm_pkg::QDEPTH - 1)) ?
					'0 : wptr_q + swm_pkg::QPTR_W'(1);
			if (pop)
				rptr_q <= (rptr_q == swm_pkg::QPTR_W'(swm_pkg::QDEPTH - 1)) ?
					'0 : rptr_q + swm_pkg::QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + swm_pkg::QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - swm_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_entry;
	end

endmodule

/* hdl/swm_back.sv */
// ----------------------------------------------------------------------------
// swm_back
// Bit-serial signed divide of sum by count, with an output register.
// ----------------------------------------------------------------------------
module swm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  swm_pkg::entry_t                    q_entry,
	output logic                               pop,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [swm_pkg::VALUE_W-1:0] mean,
	output logic [swm_pkg::CNT_W-1:0]          fill_count
);

	swm_pkg::back_state_t state_q, state_d;

	logic [swm_pkg::SUM_W-1:0]  quo_q;
	logic [swm_pkg::CNT_W-1:0]  rem_q;
	logic [swm_pkg::CNT_W-1:0]  div_q;
	logic                       neg_q;
	logic [swm_pkg::BITS_W-1:0] bits_q;
	logic                       out_valid_q;

	logic [swm_pkg::CNT_W:0]     trial;
	logic [swm_pkg::CNT_W:0]     diff;
	logic                        ge;
	logic [swm_pkg::SUM_W-1:0]   mag;
	logic [swm_pkg::SUM_W-1:0]   res;
	logic                        load, step, emit;

	always_comb begin
		trial = {rem_q, quo_q[swm_pkg::SUM_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
		mag   = q_entry.total[swm_pkg::SUM_W-1] ?
			(~q_entry.total) + swm_pkg::SUM_W'(1) : q_entry.total;
		res   = neg_q ? (~quo_q) + swm_pkg::SUM_W'(1) : quo_q;
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			swm_pkg::B_IDLE: begin
				if (q_valid) begin
					load    = 1'b1;
					state_d = swm_pkg::B_DIV;
				end
			end
			swm_pkg::B_DIV: begin
				step = 1'b1;
				if (bits_q == swm_pkg::BITS_W'(1))
					state_d = swm_pkg::B_HOLD;
			end
			swm_pkg::B_HOLD: begin
				if (!out_valid_q || result_ready) begin
					emit    = 1'b1;
					state_d = swm_pkg::B_IDLE;
				end
			end
			default: state_d = swm_pkg::B_IDLE;
		endcase
	end

	assign pop          = load;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q  <= mag;
			rem_q  <= '0;
			div_q  <= q_entry.count;
			neg_q  <= q_entry.total[swm_pkg::SUM_W-1];
			bits_q <= swm_pkg::BITS_W'(swm_pkg::SUM_W);
		end else if (step) begin
			quo_q  <= {quo_q[swm_pkg::SUM_W-2:0], ge};
			rem_q  <= ge ? diff[swm_pkg::CNT_W-1:0] : trial[swm_pkg::CNT_W-1:0];
			bits_q <= bits_q - swm_pkg::BITS_W'(1);
		end
		if (emit) begin
			mean       <= res[swm_pkg::VALUE_W-1:0];
			fill_count <= div_q;
		end
	end

endmodule

/* hdl/sliding_window_mean.sv */
// ----------------------------------------------------------------------------
// sliding_window_mean
// Moving average of signed Q16.16 samples over the last window_len samples.
// ----------------------------------------------------------------------------
// Path from sample accept to result valid: store update and queue push,
//   queue pop and divider load, 38 divide steps of one quotient bit each,
//   output register; a full queue or an unaccepted result can stall it.
// The bit-serial divider (load, 38 steps, hand-off) sets the sustained rate;
//   it takes no new word until the last is handed off. The front takes a new
//   sample only after its store update, until the 2-entry queue fills.
// Reset: arst_n clears the window (count, pointer, sum) and sets window_len
//   to 64. The sample store is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module sliding_window_mean (
	input  logic                               clk,
	input  logic                               arst_n,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swm_pkg::ADDR_W-1:0]         paddr,
	input  logic [swm_pkg::DATA_W-1:0]         pwdata,
	output logic [swm_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	// sample channel
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic signed [swm_pkg::VALUE_W-1:0] value,
	// result channel
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [swm_pkg::VALUE_W-1:0] mean,
	output logic [swm_pkg::CNT_W-1:0]          fill_count
);

	logic [swm_pkg::CNT_W-1:0] window_len_q;
	logic [swm_pkg::CNT_W-1:0] len;
	logic                      len_wr;
	logic                      reg_hit;

	logic               push, pop;
	swm_pkg::entry_t    push_entry, pop_entry;
	swm_pkg::q_status_t q_status;

	// --- config register ---------------------------------------------------
	// window_len is the only register; a write to it empties the window.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[swm_pkg::ADDR_W-1:2] == swm_pkg::REG_WINDOW_LEN);
	assign len_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? swm_pkg::DATA_W'(window_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_len_q <= swm_pkg::CNT_W'(swm_pkg::LEN_RESET);
		else if (len_wr)
			window_len_q <= pwdata[swm_pkg::CNT_W-1:0];
	end

	// zero acts as 1, anything above the store depth as the depth
	assign len = swm_pkg::eff_len(window_len_q);

	// --- front: ring store, running sum, count ------------------------------
	swm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (len_wr),
		.len          (len),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.value        (value),
		.q_status     (q_status),
		.push         (push),
		.entry        (push_entry)
	);

	// --- queue: decouples store update from the divide ----------------------
	swm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	// --- back: sum / count, truncated toward zero ---------------------------
	swm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_status.valid),
		.q_entry      (pop_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mean         (mean),
		.fill_count   (fill_count)
	);

	// --- checks -------------------------------------------------------------
	// the front only pushes when the queue has room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("queue push while full");

	// a delivered count is always within 1..MAX_WINDOW
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (fill_count != '0) &&
			(fill_count <= swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW)))
		else $error("fill_count out of range");

	// an accepted sample keeps the front busy for its store update
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("front accepted back to back");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sliding_window_mean: drives Q16.16 samples through
// a valid/ready channel and checks each mean and fill count against an
// in-bench moving-average tracker. It steps through several window_len
// settings, including zero and values above the maximum, with random
// source gaps and result backpressure in most phases, then at full speed.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HALF    = 2;
	localparam int RESET_CYC   = 7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYC   = 48;   // idle wait at the end, after the last drain
	localparam int PHASE_WORDS = 100;
	localparam int NUM_PHASES  = 8;
	localparam int REPORT_MAX  = 10;

	localparam logic [swm_pkg::ADDR_W-1:0] WINDOW_LEN_ADDR =
		{swm_pkg::REG_WINDOW_LEN, 2'b00};

	// ------------------------------------------------------------------------
	// Moving-average tracker: mirrors the ring, pointer, count and total, and
	// queues one expected (mean, count) pair per accepted sample word.
	// ------------------------------------------------------------------------
	class avg_tracker;
		typedef struct {
			logic signed [swm_pkg::VALUE_W-1:0] mean;
			logic [swm_pkg::CNT_W-1:0]          fill;
		} avg_t;

		logic signed [swm_pkg::VALUE_W-1:0] ring [swm_pkg::MAX_WINDOW];
		int unsigned                        oldest;
		int unsigned                        held;
		longint                             total;
		logic [swm_pkg::CNT_W-1:0]          len_reg;
		avg_t                               pending_means [$];
		int                                 errors;

		function new();
			len_reg = swm_pkg::CNT_W'(swm_pkg::LEN_RESET);
			oldest  = 0;
			held    = 0;
			total   = 0;
			errors  = 0;
		endfunction

		// any write to window_len empties the window
		function void load_window_len(logic [swm_pkg::CNT_W-1:0] len);
			len_reg = len;
			oldest  = 0;
			held    = 0;
			total   = 0;
		endfunction

		function int pending();
			return pending_means.size();
		endfunction

		function void add_sample(logic signed [swm_pkg::VALUE_W-1:0] v);
			int unsigned n;
			int unsigned slot;
			avg_t        e;
			// zero acts as 1, anything above the store depth as the depth
			n = len_reg;
			if (n < 1)
				n = 1;
			if (n > swm_pkg::MAX_WINDOW)
				n = swm_pkg::MAX_WINDOW;
			if (oldest >= n)
				oldest = 0;
			if (held > n)
				held = n;
			if (held >= n) begin
				// full: drop the oldest sample and overwrite its slot
				slot   = oldest;
				total -= ring[slot];
				oldest = (oldest + 1 >= n) ? 0 : oldest + 1;
			end else begin
				slot = oldest + held;
				if (slot >= n)
					slot -= n;
				held++;
			end
			ring[slot] = v;
			total     += v;
			// SV division truncates toward zero
			e.mean = swm_pkg::VALUE_W'(total / longint'(held));
			e.fill = swm_pkg::CNT_W'(held);
			pending_means.insert(pending_means.size(), e);
		endfunction

		function void check_mean(logic signed [swm_pkg::VALUE_W-1:0] mean,
				logic [swm_pkg::CNT_W-1:0] fill);
			avg_t e;
			if (pending_means.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result word: mean %0d fill %0d", mean, fill);
				return;
			end
			e = pending_means.pop_front();
			if (mean !== e.mean || fill !== e.fill) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result error: mean exp %0d got %0d, fill exp %0d got %0d",
						e.mean, mean, e.fill, fill);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT connections; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               psel         = 1'b0;
	logic                               penable      = 1'b0;
	logic                               pwrite       = 1'b0;
	logic [swm_pkg::ADDR_W-1:0]         paddr        = '0;
	logic [swm_pkg::DATA_W-1:0]         pwdata       = '0;
	logic [swm_pkg::DATA_W-1:0]         prdata;
	logic                               pready;
	logic                               sample_valid = 1'b0;
	logic                               sample_ready;
	logic signed [swm_pkg::VALUE_W-1:0] value        = '0;
	logic                               result_valid;
	logic                               result_ready = 1'b0;
	logic signed [swm_pkg::VALUE_W-1:0] mean;
	logic [swm_pkg::CNT_W-1:0]          fill_count;

	avg_tracker tracker = new();

	// idle percentages, changed by the stimulus between phases
	int src_idle_pct  = 10;
	int sink_idle_pct = 50;

	sliding_window_mean uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mean         (mean),
		.fill_count   (fill_count)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sliding_window_mean: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: outputs are sampled at the edge (pre-update values), so a
	// word counts when valid and ready were both high going into the edge.
	// Ready is re-rolled every cycle from the current idle percentage.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_mean(mean, fill_count);
		result_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// ------------------------------------------------------------------------
	// Stimulus tasks; all are entered on a rising-edge time step
	// ------------------------------------------------------------------------

	// Write in a setup phase, then an access phase; lands on the edge with penable high
	task automatic write_window_len(input logic [swm_pkg::CNT_W-1:0] len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WINDOW_LEN_ADDR;
		pwdata  <= swm_pkg::DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		tracker.load_window_len(len);
	endtask

	// Valid only drops when a gap is taken, so back-to-back words never see
	// a lower-and-raise in the same step.
	task automatic send_sample(input logic signed [swm_pkg::VALUE_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		value        <= v;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		tracker.add_sample(v);
	endtask

	// Drop valid and let every outstanding mean come back before a write.
	// Every sample yields a result, so an empty queue means the block is idle.
	task automatic drain();
		sample_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of rails, small values around zero and full-range noise
	function automatic logic signed [swm_pkg::VALUE_W-1:0] pick_value();
		logic [swm_pkg::VALUE_W-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				v = 32'h7fff_ffff;
			end
			1: begin
				v = 32'h8000_0000;
			end
			2, 3: begin
				v = $urandom_range(0, 511) - 256;
			end
			default: begin
				v = $urandom();
			end
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		logic [swm_pkg::CNT_W-1:0] phase_len [NUM_PHASES];

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset length 64, rails and truncation of small sums
		send_sample(32'h7fff_ffff);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(-32'sd1);
		send_sample(32'sd1);
		drain();

		// length zero behaves as a one-deep window
		write_window_len(7'd0);
		send_sample(32'h8000_0000);
		send_sample(32'h7fff_ffff);
		send_sample(-32'sd5);
		drain();

		// two deep: wraps every other word; -3/2 must truncate to -1
		write_window_len(7'd2);
		send_sample(-32'sd3);
		send_sample(32'sd0);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'sd1);
		send_sample(-32'sd2);
		drain();

		// above the store depth: clamps to 64
		write_window_len(7'd127);
		send_sample(-32'sd7);
		send_sample(32'sd2);
		send_sample(32'h1234_5678);
		drain();

		// --- random phases: extremes of the register plus random lengths;
		// 100 words per phase so even a 64-deep window wraps
		phase_len[0] = 7'd1;
		phase_len[1] = 7'd64;
		phase_len[2] = swm_pkg::CNT_W'($urandom_range(2, 63));
		phase_len[3] = 7'd127;
		phase_len[4] = 7'd0;
		phase_len[5] = swm_pkg::CNT_W'($urandom_range(0, 127));
		phase_len[6] = 7'd65;
		phase_len[7] = swm_pkg::CNT_W'($urandom_range(1, 64));

		for (int p = 0; p < NUM_PHASES; p++) begin
			// sender busy / receiver choked, then swapped, then full speed
			if (p < 3) begin
				src_idle_pct  = 10;
				sink_idle_pct = 50;
			end else if (p < 6) begin
				src_idle_pct  = 50;
				sink_idle_pct = 10;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			write_window_len(phase_len[p]);
			for (int i = 0; i < PHASE_WORDS; i++)
				send_sample(pick_value());
			drain();
		end

		// anything arriving now has no expectation and is flagged
		repeat (DRAIN_CYC) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("sliding_window_mean: match");
		else
			$display("sliding_window_mean: mismatch");
		$finish;
	end

endmodule

/* sliding_window_mean.f */
hdl/swm_pkg.sv
hdl/swm_ram.sv
hdl/swm_front.sv
hdl/swm_queue.sv
hdl/swm_back.sv
hdl/sliding_window_mean.sv
tb/sv/tb_top.sv
